// ===== hdl/urs_cfa_pkg.sv =====
`default_nettype none
package urs_cfa_pkg;

  localparam int unsigned TABLE_DEPTH_DEF  = 4096;
  localparam int unsigned SEARCH_STEPS_DEF = 13;
  localparam int unsigned IDX_W            = 13;
  localparam int unsigned BOUND_W          = IDX_W + 1;
  localparam int unsigned ROW_ID_W         = 12;

  localparam logic [2:0] CFA_BP   = 3'd0;
  localparam logic [2:0] CFA_SP   = 3'd1;
  localparam logic [2:0] CFA_EXPR = 3'd2;
  localparam logic [2:0] CFA_END  = 3'd3;

  localparam logic [2:0] BP_SAME   = 3'd0;
  localparam logic [2:0] BP_OFFSET = 3'd1;
  localparam logic [2:0] BP_REG    = 3'd2;
  localparam logic [2:0] BP_EXPR   = 3'd3;
  localparam logic [2:0] BP_UNDEF  = 3'd4;

  localparam logic [15:0] EXPR_PLT1 = 16'd1;
  localparam logic [15:0] EXPR_PLT2 = 16'd2;
  localparam logic [3:0]  PLT1_THR  = 4'd11;
  localparam logic [3:0]  PLT2_THR  = 4'd10;
  localparam logic [63:0] SLOT_BYTES = 64'd8;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BOTTOM,
    ST_NOROW,
    ST_EXHAUSTED,
    ST_BPRULE,
    ST_EXPR,
    ST_CFARULE,
    ST_ZEROCFA
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_CFA,
    S_FIN
  } state_t;

  typedef struct packed {
    logic signed [15:0] bp_save_off;
    logic signed [15:0] cfa_disp;
    logic [2:0]         bp_rule;
    logic [2:0]         cfa_rule;
  } rule_t;

  typedef struct packed {
    logic [63:0] pc;
    rule_t       rules;
  } row_t;

  typedef struct packed {
    logic load;
    logic mem_wr;
    logic probe;
    logic eval;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic srch_ok;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/urs_cfa_ctrl.sv =====
`default_nettype none
module urs_cfa_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_func,
  output logic                     in_ready,
  input  wire urs_cfa_pkg::dp_sts_t sts,
  output urs_cfa_pkg::dp_cmd_t     cmd
);

  urs_cfa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= urs_cfa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      urs_cfa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_func) begin
            state_nxt = urs_cfa_pkg::S_SEARCH;
          end else begin
            cmd.mem_wr = 1'b1;
            state_nxt  = urs_cfa_pkg::S_FIN;
          end
        end
      end
      urs_cfa_pkg::S_SEARCH: begin
        cmd.probe = 1'b1;
        if (sts.srch_done) begin
          state_nxt = sts.srch_ok ? urs_cfa_pkg::S_CFA : urs_cfa_pkg::S_FIN;
        end
      end
      urs_cfa_pkg::S_CFA: begin
        cmd.eval  = 1'b1;
        state_nxt = urs_cfa_pkg::S_FIN;
      end
      urs_cfa_pkg::S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = urs_cfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = urs_cfa_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/urs_cfa_dp.sv =====
`default_nettype none
module urs_cfa_dp #(
  parameter int unsigned TABLE_DEPTH  = urs_cfa_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned SEARCH_STEPS = urs_cfa_pkg::SEARCH_STEPS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire urs_cfa_pkg::dp_cmd_t      cmd,
  output urs_cfa_pkg::dp_sts_t           sts,
  input  wire logic                      in_func,
  input  wire logic [12:0]               in_index_or_low,
  input  wire logic [12:0]               in_search_high,
  input  wire logic [63:0]               in_pc_value,
  input  wire logic [2:0]                in_cfa_rule,
  input  wire logic [2:0]                in_bp_rule,
  input  wire logic signed [15:0]        in_cfa_offset,
  input  wire logic signed [15:0]        in_bp_offset,
  input  wire logic [63:0]               in_stack_pointer,
  input  wire logic [63:0]               in_frame_pointer,
  input  wire logic [63:0]               in_load_offset,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output logic [2:0]                     out_status,
  output logic [11:0]                    out_row_found,
  output logic [63:0]                    out_caller_sp,
  output logic [63:0]                    out_return_addr_location,
  output logic [63:0]                    out_saved_bp_location,
  output logic                           out_bp_unchanged
);

  localparam int unsigned ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned STEP_W  = $clog2(SEARCH_STEPS + 1);
  localparam int unsigned BOUND_W = urs_cfa_pkg::BOUND_W;
  localparam int unsigned RID_W   = urs_cfa_pkg::ROW_ID_W;

  localparam logic signed [15:0] EXPR_PLT1_S = urs_cfa_pkg::EXPR_PLT1;
  localparam logic signed [15:0] EXPR_PLT2_S = urs_cfa_pkg::EXPR_PLT2;

  urs_cfa_pkg::row_t mem_r [TABLE_DEPTH];
  urs_cfa_pkg::row_t rd_row_r;

  logic [BOUND_W-1:0]  left_r, left_nxt, right_r, right_nxt, mid_r, mid_nxt;
  logic [63:0]         adj_pc_r, adj_pc_nxt;
  logic [3:0]          pc_lo_r, pc_lo_nxt;
  logic [63:0]         sp_r, sp_nxt, bp_r, bp_nxt;
  logic [STEP_W-1:0]   steps_r, steps_nxt;
  logic                pend_r, pend_nxt;
  logic                have_r, have_nxt;
  logic [RID_W-1:0]    found_r, found_nxt;
  logic                row_ok_r, row_ok_nxt;
  logic                lookup_r, lookup_nxt;
  urs_cfa_pkg::rule_t  rules_r, rules_nxt;
  urs_cfa_pkg::status_t res_st_r, res_st_nxt;
  logic [63:0]         cfa_r, cfa_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [2:0]          out_status_r;
  logic [RID_W-1:0]    out_row_r;
  logic [63:0]         out_csp_r, out_ret_r, out_sbp_r;
  logic                out_unch_r;

  logic                wr_in_range;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  urs_cfa_pkg::row_t   wr_row;

  logic                hit, have_e, steps_full, mid_out, rd_en, srch_done;
  logic [BOUND_W-1:0]  left_e, right_e, mid_e;
  logic [BOUND_W:0]    mid_sum;
  urs_cfa_pkg::status_t srch_st, eval_st;

  logic [63:0]         cfa_off_x, bp_off_x, cfa_base, cfa_add, cfa_calc;
  logic [3:0]          plt_thr;
  logic                ok_fin, bp_keep;

  // table port
  assign wr_in_range = 32'(in_index_or_low) < TABLE_DEPTH;
  assign wr_addr     = ADDR_W'(in_index_or_low);
  assign wr_row      = '{pc: in_pc_value,
                         rules: '{bp_save_off: in_bp_offset, cfa_disp: in_cfa_offset,
                                  bp_rule: in_bp_rule, cfa_rule: in_cfa_rule}};
  assign rd_addr     = ADDR_W'(mid_e);

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && wr_in_range) begin
      mem_r[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= mem_r[rd_addr];
    end
  end

  // search step: fold in the last probe, then pick the next midpoint
  assign hit        = pend_r && (rd_row_r.pc <= adj_pc_r);
  assign have_e     = have_r || hit;
  assign left_e     = hit ? (mid_r + BOUND_W'(1)) : left_r;
  assign right_e    = (pend_r && !hit) ? mid_r : right_r;
  assign mid_sum    = {1'b0, left_e} + {1'b0, right_e};
  assign mid_e      = mid_sum[BOUND_W:1];
  assign mid_out    = 32'(mid_e) >= TABLE_DEPTH;
  assign steps_full = steps_r == STEP_W'(SEARCH_STEPS);

  always_comb begin
    srch_done = 1'b0;
    srch_st   = urs_cfa_pkg::ST_OK;
    rd_en     = 1'b0;
    if (steps_full) begin
      srch_done = 1'b1;
      srch_st   = urs_cfa_pkg::ST_EXHAUSTED;
    end else if (left_e >= right_e) begin
      srch_done = 1'b1;
      srch_st   = have_e ? urs_cfa_pkg::ST_OK : urs_cfa_pkg::ST_NOROW;
    end else if (mid_out) begin
      srch_done = 1'b1;
      srch_st   = urs_cfa_pkg::ST_NOROW;
    end else begin
      rd_en = cmd.probe;
    end
  end

  assign sts.srch_done = srch_done;
  assign sts.srch_ok   = srch_st == urs_cfa_pkg::ST_OK;
  assign sts.out_free  = !out_valid_r || out_ready;

  // rule evaluation
  assign cfa_off_x = {{48{rules_r.cfa_disp[15]}}, rules_r.cfa_disp};
  assign bp_off_x  = {{48{rules_r.bp_save_off[15]}}, rules_r.bp_save_off};
  assign plt_thr   = (rules_r.cfa_disp == EXPR_PLT1_S) ? urs_cfa_pkg::PLT1_THR
                                                        : urs_cfa_pkg::PLT2_THR;
  assign cfa_base  = (rules_r.cfa_rule == urs_cfa_pkg::CFA_BP) ? bp_r : sp_r;
  assign cfa_add   = (rules_r.cfa_rule == urs_cfa_pkg::CFA_EXPR)
                   ? (urs_cfa_pkg::SLOT_BYTES +
                      ((pc_lo_r >= plt_thr) ? urs_cfa_pkg::SLOT_BYTES : 64'd0))
                   : cfa_off_x;
  assign cfa_calc  = cfa_base + cfa_add;

  always_comb begin
    eval_st = urs_cfa_pkg::ST_OK;
    if (rules_r.cfa_rule == urs_cfa_pkg::CFA_END || rules_r.bp_rule == urs_cfa_pkg::BP_UNDEF) begin
      eval_st = urs_cfa_pkg::ST_BOTTOM;
    end else if (rules_r.bp_rule == urs_cfa_pkg::BP_REG ||
                 rules_r.bp_rule == urs_cfa_pkg::BP_EXPR) begin
      eval_st = urs_cfa_pkg::ST_BPRULE;
    end else begin
      case (rules_r.cfa_rule)
        urs_cfa_pkg::CFA_BP, urs_cfa_pkg::CFA_SP: begin
          eval_st = (cfa_calc == 64'd0) ? urs_cfa_pkg::ST_ZEROCFA : urs_cfa_pkg::ST_OK;
        end
        urs_cfa_pkg::CFA_EXPR: begin
          if (rules_r.cfa_disp != EXPR_PLT1_S && rules_r.cfa_disp != EXPR_PLT2_S) begin
            eval_st = urs_cfa_pkg::ST_EXPR;
          end else if (cfa_calc == 64'd0) begin
            eval_st = urs_cfa_pkg::ST_ZEROCFA;
          end
        end
        default: begin
          eval_st = urs_cfa_pkg::ST_CFARULE;
        end
      endcase
    end
  end

  assign ok_fin  = lookup_r && (res_st_r == urs_cfa_pkg::ST_OK);
  assign bp_keep = rules_r.bp_rule == urs_cfa_pkg::BP_SAME;

  always_comb begin
    left_nxt   = left_r;
    right_nxt  = right_r;
    mid_nxt    = mid_r;
    adj_pc_nxt = adj_pc_r;
    pc_lo_nxt  = pc_lo_r;
    sp_nxt     = sp_r;
    bp_nxt     = bp_r;
    steps_nxt  = steps_r;
    pend_nxt   = pend_r;
    have_nxt   = have_r;
    found_nxt  = found_r;
    row_ok_nxt = row_ok_r;
    lookup_nxt = lookup_r;
    rules_nxt  = rules_r;
    res_st_nxt = res_st_r;
    cfa_nxt    = cfa_r;
    if (cmd.load) begin
      left_nxt   = {1'b0, in_index_or_low};
      right_nxt  = {1'b0, in_search_high};
      adj_pc_nxt = in_pc_value - in_load_offset;
      pc_lo_nxt  = in_pc_value[3:0];
      sp_nxt     = in_stack_pointer;
      bp_nxt     = in_frame_pointer;
      steps_nxt  = '0;
      pend_nxt   = 1'b0;
      have_nxt   = 1'b0;
      found_nxt  = '0;
      row_ok_nxt = 1'b0;
      lookup_nxt = in_func;
      res_st_nxt = urs_cfa_pkg::ST_OK;
      cfa_nxt    = '0;
    end
    if (cmd.probe) begin
      left_nxt  = left_e;
      right_nxt = right_e;
      have_nxt  = have_e;
      pend_nxt  = rd_en;
      if (hit) begin
        found_nxt = mid_r[RID_W-1:0];
        rules_nxt = rd_row_r.rules;
      end
      if (rd_en) begin
        mid_nxt   = mid_e;
        steps_nxt = steps_r + STEP_W'(1);
      end
      if (srch_done) begin
        res_st_nxt = srch_st;
        row_ok_nxt = srch_st == urs_cfa_pkg::ST_OK;
      end
    end
    if (cmd.eval) begin
      res_st_nxt = eval_st;
      cfa_nxt    = cfa_calc;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      steps_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      steps_r     <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    mid_r    <= mid_nxt;
    adj_pc_r <= adj_pc_nxt;
    pc_lo_r  <= pc_lo_nxt;
    sp_r     <= sp_nxt;
    bp_r     <= bp_nxt;
    have_r   <= have_nxt;
    found_r  <= found_nxt;
    row_ok_r <= row_ok_nxt;
    lookup_r <= lookup_nxt;
    rules_r  <= rules_nxt;
    res_st_r <= res_st_nxt;
    cfa_r    <= cfa_nxt;
    if (cmd.out_load) begin
      out_status_r <= res_st_r;
      out_row_r    <= row_ok_r ? found_r : '0;
      out_csp_r    <= ok_fin ? cfa_r : 64'd0;
      out_ret_r    <= ok_fin ? (cfa_r - urs_cfa_pkg::SLOT_BYTES) : 64'd0;
      out_sbp_r    <= (ok_fin && !bp_keep) ? (cfa_r + bp_off_x) : 64'd0;
      out_unch_r   <= ok_fin && bp_keep;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_status               = out_status_r;
  assign out_row_found            = out_row_r;
  assign out_caller_sp            = out_csp_r;
  assign out_return_addr_location = out_ret_r;
  assign out_saved_bp_location    = out_sbp_r;
  assign out_bp_unchanged         = out_unch_r;

endmodule
`default_nettype wire

// ===== hdl/unwind_row_search_cfa_step.sv =====
// Write item: the row is written on the input transfer when the index is below TABLE_DEPTH;
//   the result loads in S_FIN. Lookup item: the search probes the table (one read per cycle)
//   until it ends, then S_CFA evaluates the rules if a row was found, then S_FIN loads the result.
// One item in flight: in_ready returns the cycle after the result loads, and S_FIN waits
//   while an earlier result is still stalled at the output.
// Reset clears the controller and the output valid; table rows stay undefined until written.
`default_nettype none
module unwind_row_search_cfa_step #(
  parameter int unsigned TABLE_DEPTH  = urs_cfa_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned SEARCH_STEPS = urs_cfa_pkg::SEARCH_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic [12:0]        in_index_or_low,
  input  wire logic [12:0]        in_search_high,
  input  wire logic [63:0]        in_pc_value,
  input  wire logic [2:0]         in_cfa_rule,
  input  wire logic [2:0]         in_bp_rule,
  input  wire logic signed [15:0] in_cfa_offset,
  input  wire logic signed [15:0] in_bp_offset,
  input  wire logic [63:0]        in_stack_pointer,
  input  wire logic [63:0]        in_frame_pointer,
  input  wire logic [63:0]        in_load_offset,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_status,
  output logic [11:0]             out_row_found,
  output logic [63:0]             out_caller_sp,
  output logic [63:0]             out_return_addr_location,
  output logic [63:0]             out_saved_bp_location,
  output logic                    out_bp_unchanged
);

  urs_cfa_pkg::dp_cmd_t cmd;
  urs_cfa_pkg::dp_sts_t sts;

  urs_cfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  urs_cfa_dp #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .SEARCH_STEPS (SEARCH_STEPS)
  ) u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .sts                      (sts),
    .in_func                  (in_func),
    .in_index_or_low          (in_index_or_low),
    .in_search_high           (in_search_high),
    .in_pc_value              (in_pc_value),
    .in_cfa_rule              (in_cfa_rule),
    .in_bp_rule               (in_bp_rule),
    .in_cfa_offset            (in_cfa_offset),
    .in_bp_offset             (in_bp_offset),
    .in_stack_pointer         (in_stack_pointer),
    .in_frame_pointer         (in_frame_pointer),
    .in_load_offset           (in_load_offset),
    .out_ready                (out_ready),
    .out_valid                (out_valid),
    .out_status               (out_status),
    .out_row_found            (out_row_found),
    .out_caller_sp            (out_caller_sp),
    .out_return_addr_location (out_return_addr_location),
    .out_saved_bp_location    (out_saved_bp_location),
    .out_bp_unchanged         (out_bp_unchanged)
  );

endmodule
`default_nettype wire

// ===== hdl/urs_cfa_chk.sv =====
`default_nettype none
module urs_cfa_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [63:0] out_caller_sp,
  input wire logic [63:0] out_return_addr_location,
  input wire logic [63:0] out_saved_bp_location,
  input wire logic        out_bp_unchanged
);

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_fail_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != urs_cfa_pkg::ST_OK) |->
      out_caller_sp == 64'd0 && out_return_addr_location == 64'd0 &&
      out_saved_bp_location == 64'd0 && !out_bp_unchanged)
    else $error("nonzero status with frame fields set");

  a_unchanged_bp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bp_unchanged |-> out_saved_bp_location == 64'd0)
    else $error("saved bp location set with bp unchanged");

  a_ret_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == urs_cfa_pkg::ST_OK) && (out_caller_sp != 64'd0) |->
      out_return_addr_location == out_caller_sp - urs_cfa_pkg::SLOT_BYTES)
    else $error("return address slot does not sit below the CFA");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_caller_sp) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind unwind_row_search_cfa_step urs_cfa_chk u_chk (.*);
`default_nettype wire
